// ----- hdl/bba_pkg.sv -----
`default_nettype none
package bba_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_OOM    = 2'd1,
      ST_ZERO   = 2'd2,
      ST_REJECT = 2'd3
   } status_type;

   // Control from the request side into the engine.
   typedef struct packed {
      logic start;
      logic room;
   } eng_ctl_type;

   // Status from the engine back to the request side.
   typedef struct packed {
      logic       idle;
      logic       done;
      status_type status;
   } eng_sts_type;

endpackage
`default_nettype wire

// ----- hdl/bba_engine.sv -----
`default_nettype none
module bba_engine #(
   parameter int POOL_ORDER = 16,
   parameter int MIN_ORDER  = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire bba_pkg::eng_ctl_type ctl,
   input  wire                  operation,
   input  wire  [16:0]          request_bytes,
   input  wire  [15:0]          block_offset,
   output bba_pkg::eng_sts_type sts,
   output logic [15:0]          granted_offset
);

   localparam int NORDERS = POOL_ORDER - MIN_ORDER + 1;
   localparam int UW      = (POOL_ORDER > MIN_ORDER) ? (POOL_ORDER - MIN_ORDER) : 1;
   localparam int NUNITS  = 1 << (POOL_ORDER - MIN_ORDER);
   localparam int IW      = (NORDERS > 1) ? $clog2(NORDERS) : 1;
   localparam logic [IW-1:0] TOP = IW'(NORDERS - 1);

   typedef struct packed {
      logic          head;
      logic          free;
      logic [IW-1:0] lvl;
      logic          nv;
      logic          pv;
      logic [UW-1:0] nxt;
      logic [UW-1:0] prv;
   } hdr_type;

   typedef enum logic [18:0] {
      S_INIT   = 19'd1 << 0,
      S_IDLE   = 19'd1 << 1,
      S_A_CAP  = 19'd1 << 2,
      S_RM_P   = 19'd1 << 3,
      S_RM_PW  = 19'd1 << 4,
      S_RM_N   = 19'd1 << 5,
      S_RM_NW  = 19'd1 << 6,
      S_RM_H   = 19'd1 << 7,
      S_SPLIT  = 19'd1 << 8,
      S_PUSH   = 19'd1 << 9,
      S_PUSH_H = 19'd1 << 10,
      S_PUSH_W = 19'd1 << 11,
      S_A_FIN  = 19'd1 << 12,
      S_F_CAP  = 19'd1 << 13,
      S_M_CHK  = 19'd1 << 14,
      S_M_CAP  = 19'd1 << 15,
      S_M_CLR  = 19'd1 << 16,
      S_F_FIN  = 19'd1 << 17,
      S_DONE   = 19'd1 << 18
   } state_type;

   hdr_type   hdr_mem [NUNITS];
   hdr_type   rd_ff;
   logic      mem_we;
   logic [UW-1:0] mem_addr;
   hdr_type   mem_wd;

   state_type state_ff, state_in;
   logic [UW-1:0] cu_ff, cu_in, rm_idx_ff, rm_idx_in, pidx_ff, pidx_in, bidx_ff, bidx_in;
   logic [IW-1:0] k_ff, k_in, lvl_ff, lvl_in;
   hdr_type   rm_ff, rm_in, ph_ff, ph_in;
   logic      op_ff, op_in;
   bba_pkg::status_type status_ff, status_in;
   logic [15:0] goff_ff, goff_in;

   logic [NORDERS-1:0] head_v_ff;
   logic [UW-1:0]      head_idx_ff [NORDERS];
   logic [IW-1:0]      hd_raddr;
   logic [UW-1:0]      hd_rdata;
   logic               hw_en, hw_v;
   logic [IW-1:0]      hw_addr;
   logic [UW-1:0]      hw_idx;

   // Size rounding and free-list search for an allocate, and offset checks for a free.
   logic [17:0]   need_m1;
   int            clog, kl;
   logic          found;
   logic [IW-1:0] jsel;
   logic [31:0]   off32;
   logic          off_bad;
   logic [UW-1:0] unit;

   always_comb begin
      need_m1 = 18'(request_bytes) + 18'd7;
      clog = 0;
      for (int i = 0; i < 18; i++) begin
         if (need_m1[i]) begin
            clog = i + 1;
         end
      end
      kl = (clog < MIN_ORDER) ? 0 : clog - MIN_ORDER;
      found = 1'b0;
      jsel = '0;
      for (int i = 0; i < NORDERS; i++) begin
         if (!found && i >= kl && head_v_ff[i]) begin
            found = 1'b1;
            jsel = IW'(i);
         end
      end
      off32 = 32'(block_offset);
      off_bad = ((off32 & ((32'd1 << MIN_ORDER) - 32'd1)) != 32'd0) ||
                ((off32 >> POOL_ORDER) != 32'd0);
      unit = off32[MIN_ORDER +: UW];
   end

   assign hd_raddr = (state_ff == S_IDLE) ? jsel : ph_ff.lvl;
   assign hd_rdata = head_idx_ff[hd_raddr];

   always_comb begin
      state_in = state_ff;
      cu_in = cu_ff;
      rm_idx_in = rm_idx_ff;
      pidx_in = pidx_ff;
      bidx_in = bidx_ff;
      k_in = k_ff;
      lvl_in = lvl_ff;
      rm_in = rm_ff;
      ph_in = ph_ff;
      op_in = op_ff;
      status_in = status_ff;
      goff_in = goff_ff;
      mem_we = 1'b0;
      mem_addr = cu_ff;
      mem_wd = '0;
      hw_en = 1'b0;
      hw_addr = rm_ff.lvl;
      hw_v = 1'b0;
      hw_idx = rm_ff.nxt;

      unique case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            mem_addr = '0;
            mem_wd = '0;
            mem_wd.head = 1'b1;
            mem_wd.free = 1'b1;
            mem_wd.lvl = TOP;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            goff_in = '0;
            op_in = operation;
            if (ctl.start) begin
               if (operation == bba_pkg::OP_ALLOC) begin
                  mem_addr = hd_rdata;
                  cu_in = hd_rdata;
                  k_in = IW'(kl);
                  lvl_in = jsel;
                  if (request_bytes == 17'd0) begin
                     status_in = bba_pkg::ST_ZERO;
                     state_in = S_DONE;
                  end else if (!found) begin
                     status_in = bba_pkg::ST_OOM;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_A_CAP;
                  end
               end else begin
                  mem_addr = unit;
                  cu_in = unit;
                  if (off_bad) begin
                     status_in = bba_pkg::ST_REJECT;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_F_CAP;
                  end
               end
            end
         end
         S_A_CAP: begin
            rm_in = rd_ff;
            rm_idx_in = cu_ff;
            state_in = S_RM_P;
         end
         S_RM_P: begin
            mem_addr = rm_ff.prv;
            state_in = rm_ff.pv ? S_RM_PW : S_RM_N;
         end
         S_RM_PW: begin
            mem_we = 1'b1;
            mem_addr = rm_ff.prv;
            mem_wd = rd_ff;
            mem_wd.nxt = rm_ff.nxt;
            if (!rm_ff.nv) begin
               mem_wd.nv = 1'b0;
            end
            state_in = S_RM_N;
         end
         S_RM_N: begin
            mem_addr = rm_ff.nxt;
            state_in = rm_ff.nv ? S_RM_NW : S_RM_H;
         end
         S_RM_NW: begin
            mem_we = 1'b1;
            mem_addr = rm_ff.nxt;
            mem_wd = rd_ff;
            mem_wd.prv = rm_ff.prv;
            if (!rm_ff.pv) begin
               mem_wd.pv = 1'b0;
            end
            state_in = S_RM_H;
         end
         S_RM_H: begin
            hw_en = !rm_ff.pv;
            hw_addr = rm_ff.lvl;
            hw_v = rm_ff.nv;
            hw_idx = rm_ff.nxt;
            state_in = (op_ff == bba_pkg::OP_FREE) ? S_M_CLR : S_SPLIT;
         end
         S_SPLIT: begin
            if (lvl_ff != k_ff) begin
               lvl_in = lvl_ff - IW'(1);
               ph_in = '0;
               ph_in.head = 1'b1;
               ph_in.lvl = lvl_ff - IW'(1);
               pidx_in = cu_ff + (UW'(1) << (lvl_ff - IW'(1)));
               state_in = S_PUSH;
            end else begin
               state_in = S_A_FIN;
            end
         end
         S_PUSH: begin
            mem_addr = hd_rdata;
            ph_in.free = 1'b1;
            ph_in.pv = 1'b0;
            ph_in.nv = head_v_ff[ph_ff.lvl];
            ph_in.nxt = hd_rdata;
            state_in = head_v_ff[ph_ff.lvl] ? S_PUSH_H : S_PUSH_W;
         end
         S_PUSH_H: begin
            mem_we = 1'b1;
            mem_addr = hd_rdata;
            mem_wd = rd_ff;
            mem_wd.prv = pidx_ff;
            mem_wd.pv = 1'b1;
            state_in = S_PUSH_W;
         end
         S_PUSH_W: begin
            mem_we = 1'b1;
            mem_addr = pidx_ff;
            mem_wd = ph_ff;
            hw_en = 1'b1;
            hw_addr = ph_ff.lvl;
            hw_v = 1'b1;
            hw_idx = pidx_ff;
            if (op_ff == bba_pkg::OP_FREE) begin
               status_in = bba_pkg::ST_DONE;
               state_in = S_DONE;
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_A_FIN: begin
            mem_we = 1'b1;
            mem_addr = cu_ff;
            mem_wd = '0;
            mem_wd.head = 1'b1;
            mem_wd.lvl = k_ff;
            goff_in = 16'(32'(cu_ff) << MIN_ORDER);
            status_in = bba_pkg::ST_DONE;
            state_in = S_DONE;
         end
         S_F_CAP: begin
            lvl_in = rd_ff.lvl;
            if (!rd_ff.head || rd_ff.free) begin
               status_in = bba_pkg::ST_REJECT;
               state_in = S_DONE;
            end else begin
               state_in = S_M_CHK;
            end
         end
         S_M_CHK: begin
            bidx_in = cu_ff ^ (UW'(1) << lvl_ff);
            mem_addr = bidx_in;
            state_in = (lvl_ff == TOP) ? S_F_FIN : S_M_CAP;
         end
         S_M_CAP: begin
            rm_in = rd_ff;
            rm_idx_in = bidx_ff;
            if (rd_ff.head && rd_ff.free && rd_ff.lvl == lvl_ff) begin
               state_in = S_RM_P;
            end else begin
               state_in = S_F_FIN;
            end
         end
         S_M_CLR: begin
            // The upper of the two buddies stops being a block start.
            mem_we = 1'b1;
            mem_addr = (cu_ff > rm_idx_ff) ? cu_ff : rm_idx_ff;
            mem_wd = '0;
            cu_in = (cu_ff > rm_idx_ff) ? rm_idx_ff : cu_ff;
            lvl_in = lvl_ff + IW'(1);
            state_in = S_M_CHK;
         end
         S_F_FIN: begin
            ph_in = '0;
            ph_in.head = 1'b1;
            ph_in.lvl = lvl_ff;
            pidx_in = cu_ff;
            state_in = S_PUSH;
         end
         S_DONE: begin
            if (ctl.room) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hdr_mem[mem_addr] <= mem_wd;
      end
      rd_ff <= hdr_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         head_v_ff <= {1'b1, {(NORDERS-1){1'b0}}};
         head_idx_ff[NORDERS-1] <= '0;
      end else begin
         state_ff <= state_in;
         if (hw_en) begin
            head_v_ff[hw_addr] <= hw_v;
            head_idx_ff[hw_addr] <= hw_idx;
         end
      end
      cu_ff <= cu_in;
      rm_idx_ff <= rm_idx_in;
      pidx_ff <= pidx_in;
      bidx_ff <= bidx_in;
      k_ff <= k_in;
      lvl_ff <= lvl_in;
      rm_ff <= rm_in;
      ph_ff <= ph_in;
      op_ff <= op_in;
      status_ff <= status_in;
      goff_ff <= goff_in;
   end

   assign sts.idle = (state_ff == S_IDLE);
   assign sts.done = (state_ff == S_DONE) && ctl.room;
   assign sts.status = status_ff;
   assign granted_offset = goff_ff;

endmodule
`default_nettype wire

// ----- hdl/buddy_block_allocator.sv -----
`default_nettype none
// Channel   Direction  Ports
// request   in         req_valid, req_ready, req_operation, req_request_bytes,
//                      req_block_offset
// response  out        rsp_valid, rsp_ready, rsp_granted_offset, rsp_status
//
// One request is worked on at a time by a sequencer around a single-port header
// memory, one access per cycle. An allocate unlinks the chosen free block and
// then splits it order by order; a free checks the header and then merges with
// free buddies order by order. After reset S_INIT writes the whole-pool header.
// A finished response waits in the output register; a new request is taken
// meanwhile, and the engine holds its next response until that register frees.
module buddy_block_allocator #(
   parameter int POOL_ORDER = 16,
   parameter int MIN_ORDER  = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_operation,
   input  wire  [16:0] req_request_bytes,
   input  wire  [15:0] req_block_offset,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_granted_offset,
   output logic [1:0]  rsp_status
);

   bba_pkg::eng_ctl_type ctl;
   bba_pkg::eng_sts_type sts;
   logic [15:0] eng_offset;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_offset_ff, rsp_offset_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // A request is taken whenever the engine sits idle.
   assign req_ready = sts.idle;
   assign ctl.start = req_valid && sts.idle;
   // The engine may hand over a response when the output register is free or
   // is being emptied in this cycle.
   assign ctl.room = !rsp_valid_ff || rsp_ready;

   bba_engine #(
      .POOL_ORDER(POOL_ORDER),
      .MIN_ORDER (MIN_ORDER)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .operation     (req_operation),
      .request_bytes (req_request_bytes),
      .block_offset  (req_block_offset),
      .sts           (sts),
      .granted_offset(eng_offset)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      if (sts.done) begin
         rsp_valid_in = 1'b1;
         rsp_offset_in = eng_offset;
         rsp_status_in = 2'(sts.status);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_granted_offset = rsp_offset_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

// ----- bench/bba_checker.sv -----
`default_nettype none
module bba_checker #(
   parameter int POOL_ORDER = 16,
   parameter int MIN_ORDER  = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  wire         req_operation,
   input  wire  [16:0] req_request_bytes,
   input  wire  [15:0] req_block_offset,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire  [15:0] rsp_granted_offset,
   input  wire  [1:0]  rsp_status,
   output int          fail_count,
   output int          pending_count
);

   localparam int NUNITS  = 1 << (POOL_ORDER - MIN_ORDER);
   localparam int NORDERS = POOL_ORDER - MIN_ORDER + 1;

   typedef struct {
      logic [15:0]         offset;
      bba_pkg::status_type status;
   } grant_type;

   // Shadow of the header memory and the free-list heads.
   bit hdr_head[NUNITS];
   bit hdr_free[NUNITS];
   bit hdr_has_next[NUNITS];
   bit hdr_has_prev[NUNITS];
   int hdr_order[NUNITS];
   int hdr_next[NUNITS];
   int hdr_prev[NUNITS];
   bit list_valid[NORDERS];
   int list_head[NORDERS];

   grant_type expected_grants[$];

   function automatic void push_free(int u);
      int l;
      l = hdr_order[u] - MIN_ORDER;
      hdr_free[u]     = 1;
      hdr_has_next[u] = 0;
      hdr_has_prev[u] = 0;
      if (list_valid[l]) begin
         hdr_next[u]     = list_head[l];
         hdr_has_next[u] = 1;
         hdr_prev[list_head[l]]     = u;
         hdr_has_prev[list_head[l]] = 1;
      end
      list_valid[l] = 1;
      list_head[l]  = u;
   endfunction

   function automatic void unlink_free(int u);
      int l;
      bit hp, hn;
      l  = hdr_order[u] - MIN_ORDER;
      hp = hdr_has_prev[u];
      hn = hdr_has_next[u];
      if (hp) hdr_next[hdr_prev[u]] = hdr_next[u];
      if (hp && !hn) hdr_has_next[hdr_prev[u]] = 0;
      if (hn) begin
         hdr_prev[hdr_next[u]] = hdr_prev[u];
         if (!hp) hdr_has_prev[hdr_next[u]] = 0;
      end
      if (!hp) begin
         list_valid[l] = hn;
         list_head[l]  = hn ? hdr_next[u] : 0;
      end
      hdr_free[u]     = 0;
      hdr_has_next[u] = 0;
      hdr_has_prev[u] = 0;
   endfunction

   function automatic void clear_pool();
      for (int i = 0; i < NUNITS; i++) begin
         hdr_head[i] = 0; hdr_free[i] = 0; hdr_has_next[i] = 0; hdr_has_prev[i] = 0;
         hdr_order[i] = 0; hdr_next[i] = 0; hdr_prev[i] = 0;
      end
      for (int i = 0; i < NORDERS; i++) begin
         list_valid[i] = 0;
         list_head[i]  = 0;
      end
      hdr_head[0]  = 1;
      hdr_order[0] = POOL_ORDER;
      push_free(0);
   endfunction

   function automatic void mark_head(int u, int ord);
      hdr_head[u] = 1; hdr_free[u] = 0; hdr_has_next[u] = 0; hdr_has_prev[u] = 0;
      hdr_order[u] = ord;
   endfunction

   function automatic void clear_flags(int u);
      hdr_head[u] = 0; hdr_free[u] = 0; hdr_has_next[u] = 0; hdr_has_prev[u] = 0;
   endfunction

   function automatic grant_type predict_alloc(logic [16:0] bytes);
      grant_type g;
      longint need;
      int k, j, u, half;
      g.offset = '0;
      g.status = bba_pkg::ST_DONE;
      if (bytes == 0) begin
         g.status = bba_pkg::ST_ZERO;
         return g;
      end
      need = longint'(bytes) + 8;
      k = MIN_ORDER;
      while (k <= POOL_ORDER && (longint'(1) << k) < need) k++;
      j = k;
      while (j <= POOL_ORDER && !list_valid[j - MIN_ORDER]) j++;
      if (k > POOL_ORDER || j > POOL_ORDER) begin
         g.status = bba_pkg::ST_OOM;
         return g;
      end
      u = list_head[j - MIN_ORDER];
      unlink_free(u);
      while (j > k) begin
         j--;
         half = u + (1 << (j - MIN_ORDER));
         mark_head(half, j);
         push_free(half);
      end
      mark_head(u, k);
      g.offset = 16'(u << MIN_ORDER);
      return g;
   endfunction

   function automatic grant_type predict_free(logic [15:0] off);
      grant_type g;
      int u, b, ord;
      g.offset = '0;
      g.status = bba_pkg::ST_DONE;
      u = int'(off) >> MIN_ORDER;
      if ((int'(off) & ((1 << MIN_ORDER) - 1)) != 0 || u >= NUNITS ||
          !hdr_head[u] || hdr_free[u]) begin
         g.status = bba_pkg::ST_REJECT;
         return g;
      end
      ord = hdr_order[u];
      while (ord < POOL_ORDER) begin
         b = u ^ (1 << (ord - MIN_ORDER));
         if (!(hdr_head[b] && hdr_free[b]) || hdr_order[b] != ord) break;
         unlink_free(b);
         if (b < u) begin
            clear_flags(u);
            u = b;
         end else begin
            clear_flags(b);
         end
         ord++;
         mark_head(u, ord);
      end
      mark_head(u, ord);
      push_free(u);
      return g;
   endfunction

   initial begin
      fail_count = 0;
      clear_pool();
   end

   assign pending_count = expected_grants.size();

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         clear_pool();
         expected_grants.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_operation == bba_pkg::OP_ALLOC)
               expected_grants.push_back(predict_alloc(req_request_bytes));
            else
               expected_grants.push_back(predict_free(req_block_offset));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $display("%0t: response with none expected: offset %h status %0d",
                        $time, rsp_granted_offset, rsp_status);
               fail_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_granted_offset !== want.offset) begin
                  $display("%0t: granted_offset expected %h actual %h",
                           $time, want.offset, rsp_granted_offset);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;

   // Watchdog limit in cycles without any handshake. It lies well above the slowest
   // request and the long receiver hold-off.
   localparam int STALL_LIMIT = 5000;
   localparam int PRESSURE_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [16:0] req_request_bytes;
   logic [15:0] req_block_offset;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_granted_offset;
   logic [1:0]  rsp_status;

   int fail_count;
   int pending_count;

   // Idling percentages for the current phase, set by the stimulus process.
   int send_idle_pct;
   int recv_stall_pct;
   // Bumped by the stimulus process to ask the receiver for a long hold-off.
   int pressure_requests;

   // Operations accepted but not yet answered, and offsets currently held.
   logic        open_ops[$];
   logic [15:0] held_blocks[$];
   // Every offset ever granted; its header has been written at least once, so
   // a stale free of it is answered from defined state.
   logic [15:0] granted_ever[$];

   buddy_block_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_request_bytes(req_request_bytes),
      .req_block_offset(req_block_offset),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_granted_offset(rsp_granted_offset), .rsp_status(rsp_status)
   );

   bba_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_request_bytes(req_request_bytes),
      .req_block_offset(req_block_offset),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_granted_offset(rsp_granted_offset), .rsp_status(rsp_status),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The stimulus keeps track of which blocks it currently owns, so that most
   // frees name a live block and the heap is split and merged in depth.
   always @(posedge clock) begin
      logic op;
      if (!reset) begin
         if (req_valid && req_ready) open_ops.push_back(req_operation);
         if (rsp_valid && rsp_ready && open_ops.size() > 0) begin
            op = open_ops.pop_front();
            if (op == bba_pkg::OP_ALLOC && rsp_status == bba_pkg::ST_DONE) begin
               held_blocks.push_back(rsp_granted_offset);
               granted_ever.push_back(rsp_granted_offset);
            end
         end
      end
   end

   // The watchdog ends the run if no handshake happens for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // The receiver stalls at random, and holds off entirely for a long stretch
   // whenever the stimulus asks for it, so that the block backs up.
   initial begin
      int hold_left;
      int seen_requests;
      hold_left = 0;
      seen_requests = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_requests != seen_requests) begin
            seen_requests = pressure_requests;
            hold_left = PRESSURE_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Offers one request, entering at a falling edge and leaving just after the
   // rising edge at which it was accepted. Valid only drops when an idle gap
   // is taken, so it is never lowered and raised within one time step.
   task automatic offer_request(input logic op, input logic [16:0] bytes,
                                input logic [15:0] off);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_operation     = op;
      req_request_bytes = bytes;
      req_block_offset  = off;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic alloc_request(input logic [16:0] bytes);
      offer_request(bba_pkg::OP_ALLOC, bytes, 16'($urandom));
   endtask

   task automatic free_request(input logic [15:0] off);
      offer_request(bba_pkg::OP_FREE, 17'($urandom), off);
   endtask

   // Frees a block that the stimulus believes it owns; none owned means an
   // unaligned offset, which is turned away before any header is read.
   task automatic free_held_block();
      int idx;
      logic [15:0] off;
      if (held_blocks.size() == 0) begin
         off = 16'($urandom) | 16'd1;
      end else begin
         idx = $urandom_range(0, held_blocks.size() - 1);
         off = held_blocks[idx];
         held_blocks.delete(idx);
      end
      free_request(off);
   endtask

   // A free that is mostly turned away: an unaligned offset, or an offset once
   // granted that may since have been freed or merged into a larger block.
   task automatic free_stale_block();
      logic [15:0] off;
      if (granted_ever.size() == 0 || $urandom_range(0, 1) == 0) begin
         off = 16'($urandom) | 16'd1;
      end else begin
         off = granted_ever[$urandom_range(0, granted_ever.size() - 1)];
      end
      free_request(off);
   endtask

   // One random request: mostly well-formed allocates of modest size and
   // frees of owned blocks, with some large sizes, raw noise and bad frees.
   task automatic random_request();
      int pick;
      int free_pct;
      logic [16:0] bytes;
      pick = $urandom_range(0, 99);
      free_pct = (held_blocks.size() > 40) ? 70 : 45;
      if (pick < free_pct) begin
         free_held_block();
      end else if (pick < free_pct + 5) begin
         free_stale_block();
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70) bytes = 17'($urandom_range(1, 250));
         else if (pick < 90) bytes = 17'($urandom_range(1, 4096));
         else if (pick < 97) bytes = 17'($urandom_range(0, 32768));
         else bytes = 17'($urandom);
         alloc_request(bytes);
      end
   endtask

   // Waits until every response has arrived and the engine has settled.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   initial begin
      int idle_table [4];
      int stall_table [4];
      idle_table  = '{0, 65, 0, 18};
      stall_table = '{0, 0, 65, 18};

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = bba_pkg::OP_ALLOC;
      req_request_bytes = '0;
      req_block_offset  = '0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      pressure_requests = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: the edges of the size rounding, the whole pool, too
      // large a request, the zero-size request and each kind of rejected free.
      alloc_request(17'd0);
      alloc_request(17'd65536);
      alloc_request(17'h1FFFF);
      alloc_request(17'd65528);       // exactly the whole pool
      alloc_request(17'd1);           // nothing left
      free_request(16'd0);
      free_request(16'd0);            // already free
      alloc_request(17'd1);
      alloc_request(17'd8);           // smallest block exactly
      alloc_request(17'd9);           // one over, rounds up an order
      alloc_request(17'd32760);
      free_request(16'd8);            // unaligned
      free_request(16'hFFFF);
      free_request(16'd16);
      free_request(16'd0);
      free_request(16'd16);           // no longer the start of a block
      free_request(16'd32);
      free_request(16'd32768);        // merges back to the whole pool
      alloc_request(17'd65529);       // one over the pool
      alloc_request(17'd24);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_table[phase];
         recv_stall_pct = stall_table[phase];
         for (int n = 0; n < 185; n++) begin
            if (phase == 0 && n == 60) pressure_requests++;
            random_request();
         end
         // After the last phase, hand back everything still owned.
         if (phase == 3) begin
            drain();
            while (held_blocks.size() > 0) free_held_block();
         end
      end

      drain();
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
